@@ rtl/nss_pkg.sv @@
// nss_pkg: shared types for the name similarity scorer.
// No dependencies.
package nss_pkg;

   typedef struct packed {
      logic       operation;
      logic [7:0] character;
      logic       is_first;
      logic       is_last;
      logic       is_empty;
   } req_type;

   typedef struct packed {
      logic [6:0]  edit_distance;
      logic [16:0] similarity;
      logic        substring_found;
      logic        overflow;
   } rsp_type;

   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_NAME  = 1'b1;

   localparam logic [7:0] UNDERSCORE = 8'h5f;

   // One normalized character command for the back end.
   typedef struct packed {
      logic       is_name;   // target string
      logic       restart;   // restart target string before push
      logic       push;      // push chr
      logic [7:0] chr;
      logic       emit;      // emit result after push
   } cmd_type;

   typedef enum logic [2:0] {
      BE_IDLE, BE_ROW, BE_DIV, BE_OUT
   } be_state_type;

endpackage

@@ rtl/nss_front.sv @@
// nss_front: accepts raw bytes, splits uppercase bytes after the first into '_' and letter.
// Depends on nss_pkg.
module nss_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nss_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output nss_pkg::cmd_type cmd_data
);
   import nss_pkg::*;

   logic    pend_ff, pend_in;
   cmd_type hold_ff, hold_in;
   cmd_type first_c, second_c;
   logic    upper, need_two;

   always_comb begin
      upper = (req_data.character >= 8'h41) && (req_data.character <= 8'h5a);
      need_two = upper && !req_data.is_first && !req_data.is_empty;
      first_c.is_name = (req_data.operation == OP_NAME);
      first_c.restart = req_data.is_first || req_data.is_empty ||
                        (req_data.operation == OP_QUERY);
      first_c.push = !req_data.is_empty;
      first_c.chr = need_two ? UNDERSCORE :
                    (upper ? req_data.character + 8'd32 : req_data.character);
      first_c.emit = (req_data.operation == OP_NAME) &&
                     (req_data.is_empty || (req_data.is_last && !need_two));
      second_c.is_name = first_c.is_name;
      second_c.restart = 1'b0;
      second_c.push = 1'b1;
      second_c.chr = req_data.character + 8'd32;
      second_c.emit = (req_data.operation == OP_NAME) && req_data.is_last;
      // query items always restart the candidate; back end does so on any query command
      if (req_data.operation == OP_QUERY && !req_data.is_first && !req_data.is_empty)
         first_c.restart = 1'b0;
      second_c.restart = 1'b0;

      cmd_valid = pend_ff || req_valid;
      cmd_data  = pend_ff ? hold_ff : first_c;
      req_ready = !pend_ff && cmd_ready;
      pend_in = pend_ff;
      hold_in = hold_ff;
      if (pend_ff) begin
         if (cmd_ready) pend_in = 1'b0;
      end else if (req_valid && cmd_ready && need_two) begin
         pend_in = 1'b1;
         hold_in = second_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else pend_ff <= pend_in;
      hold_ff <= hold_in;
   end
endmodule

@@ rtl/nss_queue.sv @@
// nss_queue: two-entry FIFO of normalized character commands.
// Depends on nss_pkg.
module nss_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  nss_pkg::cmd_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output nss_pkg::cmd_type out_data
);
   import nss_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= in_data;
   end
endmodule

@@ rtl/nss_back.sv @@
// nss_back: edit-distance row, shift-and match and result divider.
// Depends on nss_pkg.
module nss_back #(
   parameter int MAX_LEN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  nss_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nss_pkg::rsp_type rsp_data
);
   import nss_pkg::*;

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // row entry j (1..MAX_LEN) lives at index j-1 as {match bit, distance};
   // entry 0 is the name length and match bit 0 is always set
   logic [7:0]    qs_ff [MAX_LEN];
   logic [LW:0]   row_ff [MAX_LEN];
   logic [7:0]    qs_rd_ff;
   logic [LW:0]   row_rd_ff;
   logic [LW-1:0] qlen_ff, qlen_in;
   logic          qovf_ff, qovf_in;
   logic [LW-1:0] nlen_ff, nlen_in;
   logic          seen_ff, seen_in, novf_ff, novf_in;
   be_state_type  st_ff, st_in;
   logic [7:0]    chr_ff, chr_in;
   logic          emit_ff, emit_in;
   logic          fresh_ff, fresh_in;
   logic [LW-1:0] j_ff, j_in;
   logic [LW-1:0] diag_ff, diag_in;
   logic [LW-1:0] left_ff, left_in;
   logic          mvp_ff, mvp_in;
   logic [LW-1:0] dlast_ff, dlast_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [16:0]   quo_ff, quo_in;
   logic [LW-1:0] m_ff, m_in;
   logic [4:0]    k_ff, k_in;
   rsp_type       out_ff, out_in;
   logic          ov_ff, ov_in;
   logic          qwe, rwe;
   logic [AW-1:0] rd_addr, rwa;
   logic [LW:0]   rwd;

   logic [LW-1:0] d_now, up, mlen, qbase, nbase, jm1;
   logic [LW:0]   best, alt, trial, diff;
   logic          eq, mv_old, mv_new;

   always_comb begin
      st_in = st_ff; qlen_in = qlen_ff; qovf_in = qovf_ff;
      nlen_in = nlen_ff; seen_in = seen_ff; novf_in = novf_ff; chr_in = chr_ff;
      emit_in = emit_ff; fresh_in = fresh_ff; j_in = j_ff; diag_in = diag_ff;
      left_in = left_ff; mvp_in = mvp_ff; dlast_in = dlast_ff;
      rem_in = rem_ff; quo_in = quo_ff; m_in = m_ff; k_in = k_ff;
      out_in = out_ff; ov_in = ov_ff;
      qwe = 1'b0; rwe = 1'b0; rd_addr = '0; rwa = '0; rwd = '0;
      cmd_ready = 1'b0;
      qbase = qlen_ff; nbase = nlen_ff;
      jm1 = j_ff - 1'b1;
      d_now = (nlen_ff == '0) ? qlen_ff : ((qlen_ff == '0) ? nlen_ff : dlast_ff);
      mlen = (qlen_ff > nlen_ff) ? qlen_ff : nlen_ff;
      up = '0; best = '0; alt = '0; trial = '0; diff = '0;
      eq = 1'b0; mv_old = 1'b0; mv_new = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (st_ff)
         BE_IDLE: begin
            cmd_ready = 1'b1;
            k_in = '0;
            if (cmd_valid) begin
               emit_in = cmd_data.emit && cmd_data.is_name;
               chr_in = cmd_data.chr;
               if (!cmd_data.is_name || cmd_data.restart) begin
                  nbase = '0;
                  nlen_in = '0; seen_in = 1'b0; novf_in = 1'b0;
               end
               if (!cmd_data.is_name) begin
                  if (cmd_data.restart) begin
                     qbase = '0;
                     qlen_in = '0; qovf_in = 1'b0;
                  end
                  if (cmd_data.push) begin
                     if (qbase >= LW'(MAX_LEN)) qovf_in = 1'b1;
                     else begin
                        qwe = 1'b1;
                        qlen_in = qbase + 1'b1;
                     end
                  end
               end else if (cmd_data.push && nbase >= LW'(MAX_LEN)) begin
                  novf_in = 1'b1;
                  if (emit_in) st_in = BE_DIV;
               end else if (cmd_data.push) begin
                  nlen_in = nbase + 1'b1;
                  fresh_in = (nbase == '0);
                  diag_in = nbase;
                  left_in = nlen_in;
                  mvp_in = 1'b1;
                  j_in = LW'(1);
                  if (qlen_ff != '0) st_in = BE_ROW;
                  else if (emit_in) st_in = BE_DIV;
               end else if (emit_in) st_in = BE_DIV;
            end
         end
         BE_ROW: begin
            // a freshly restarted row reads as distance j, match bit clear
            mv_old = fresh_ff ? 1'b0 : row_rd_ff[LW];
            up = fresh_ff ? j_ff : row_rd_ff[LW-1:0];
            eq = (qs_rd_ff == chr_ff);
            best = {1'b0, up} + 1'b1;
            alt = {1'b0, left_ff} + 1'b1;
            if (alt < best) best = alt;
            alt = {1'b0, diag_ff} + {{LW{1'b0}}, !eq};
            if (alt < best) best = alt;
            mv_new = mvp_ff && eq;
            rwe = 1'b1;
            rwa = jm1[AW-1:0];
            rwd = {mv_new, best[LW-1:0]};
            diag_in = up;
            left_in = best[LW-1:0];
            mvp_in = mv_old;
            if (j_ff == qlen_ff) begin
               dlast_in = best[LW-1:0];
               if (mv_new) seen_in = 1'b1;
               st_in = emit_ff ? BE_DIV : BE_IDLE;
            end else begin
               rd_addr = j_ff[AW-1:0];
               j_in = j_ff + 1'b1;
            end
         end
         BE_DIV: begin
            if (k_ff == 5'd0) begin
               m_in = mlen;
               rem_in = mlen - d_now;
               quo_in = '0;
            end else if (k_ff == 5'd1) begin
               if (rem_ff >= m_ff && m_ff != '0) begin
                  rem_in = rem_ff - m_ff;
                  quo_in = 17'd1;
               end else begin
                  quo_in = 17'd0;
               end
            end else begin
               trial = {rem_ff, 1'b0};
               diff = trial - {1'b0, m_ff};
               if (trial >= {1'b0, m_ff}) begin
                  rem_in = diff[LW-1:0];
                  quo_in = {quo_ff[15:0], 1'b1};
               end else begin
                  rem_in = trial[LW-1:0];
                  quo_in = {quo_ff[15:0], 1'b0};
               end
            end
            k_in = k_ff + 1'b1;
            if (k_ff == 5'd17) st_in = BE_OUT;
         end
         BE_OUT: begin
            if (!ov_ff || rsp_ready) begin
               out_in.edit_distance = 7'(d_now);
               out_in.similarity = (m_ff == '0) ? 17'd0 : quo_ff;
               out_in.substring_found = seen_ff || (qlen_ff == '0);
               out_in.overflow = qovf_ff || novf_ff;
               ov_in = 1'b1;
               st_in = BE_IDLE;
               nlen_in = '0; seen_in = 1'b0; novf_in = 1'b0;
            end
         end
         default: st_in = BE_IDLE;
      endcase
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BE_IDLE;
         qlen_ff <= '0; qovf_ff <= 1'b0;
         nlen_ff <= '0; seen_ff <= 1'b0; novf_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         qlen_ff <= qlen_in; qovf_ff <= qovf_in;
         nlen_ff <= nlen_in; seen_ff <= seen_in; novf_ff <= novf_in;
         ov_ff <= ov_in;
      end
      if (qwe) qs_ff[qbase[AW-1:0]] <= cmd_data.chr;
      if (rwe) row_ff[rwa] <= rwd;
      qs_rd_ff <= qs_ff[rd_addr];
      row_rd_ff <= row_ff[rd_addr];
      chr_ff <= chr_in; emit_ff <= emit_in; fresh_ff <= fresh_in;
      j_ff <= j_in; diag_ff <= diag_in; left_ff <= left_in; mvp_ff <= mvp_in;
      dlast_ff <= dlast_in;
      rem_ff <= rem_in; quo_ff <= quo_in; m_ff <= m_in; k_ff <= k_in;
      out_ff <= out_in;
   end
endmodule

@@ rtl/name_similarity_scorer.sv @@
// Name similarity scorer. A query name is loaded one byte per transaction, then
// candidate names are scored against it: Levenshtein distance, Q1.16 similarity,
// substring flag and overflow flag, one result per candidate. The distance row
// unit takes a new normalized character only after its row pass over the query,
// and each result then passes a serial divider. The front end splits uppercase
// bytes after the first; a two-entry queue decouples it from the back end.
module name_similarity_scorer #(
   parameter int MAX_LEN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nss_pkg::rsp_type rsp_data
);
   import nss_pkg::*;

   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_data, q_data;

   nss_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
   );

   nss_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   nss_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
